// ----- rtl/core/oal_pkg.sv -----
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types and codes for the ordered array list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

	// fixed field widths of the stream payload
	localparam int KIND_W  = 3;
	localparam int POS_W   = 5;
	localparam int VALUE_W = 32;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 40;

	// request kinds
	localparam logic [KIND_W-1:0] K_INSERT_AT    = 3'd0;
	localparam logic [KIND_W-1:0] K_REMOVE_VALUE = 3'd1;
	localparam logic [KIND_W-1:0] K_REMOVE_AT    = 3'd2;
	localparam logic [KIND_W-1:0] K_POP_BACK     = 3'd3;
	localparam logic [KIND_W-1:0] K_REPLACE_AT   = 3'd4;
	localparam logic [KIND_W-1:0] K_MEMBER_TEST  = 3'd5;

	// result status
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

	// update broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_NONE,
		OP_INS,
		OP_DEL,
		OP_REPL
	} op_t;

	typedef struct packed {
		op_t  op;
		logic cmp_en;
	} cell_ctl_t;

endpackage

// ----- rtl/core/oal_cell.sv -----
// ----------------------------------------------------------------------------
// oal_cell
// One list slot: holds a word, compares it with the search word, takes the
// word of a neighbor on insert or remove shifts and the write word as target.
// ----------------------------------------------------------------------------
module oal_cell #(
	parameter int IDX        = 0,
	parameter int IDX_W      = 4,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  oal_pkg::cell_ctl_t    ctl,
	input  logic [IDX_W-1:0]      tgt,
	input  logic [DATA_WIDTH-1:0] word,
	input  logic [DATA_WIDTH-1:0] prev_data,
	input  logic [DATA_WIDTH-1:0] next_data,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  hit
);
	import oal_pkg::*;

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  hit_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_INS: begin
				if (MY_IDX > tgt) begin
					data_q <= prev_data;
				end else if (MY_IDX == tgt) begin
					data_q <= word;
				end
			end
			OP_DEL: begin
				if (MY_IDX >= tgt) begin
					data_q <= next_data;
				end
			end
			OP_REPL: begin
				if (MY_IDX == tgt) begin
					data_q <= word;
				end
			end
			default: begin
			end
		endcase
	end

	// compare is taken on the input transfer, entries are stable until commit
	always_ff @(posedge clk) begin
		if (ctl.cmp_en) begin
			hit_q <= (data_q == word);
		end
	end

	assign data = data_q;
	assign hit  = hit_q;

endmodule

// ----- rtl/core/ordered_array_list_engine.sv -----
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Ordered list of up to CAPACITY words held in a chain of cells; insert,
// remove by position or value, pop, replace and membership test.
// ----------------------------------------------------------------------------
// A request is taken in IDLE; its result is registered for output at commit
// in EXEC, and no new request is taken before then. The transfer compares the
// search word in all cells; commit picks the first hit and shifts the chain.
// A result waiting on m_tready holds the commit of the next request.
// Reset: arst_n clears the entry count, the control state and m_tvalid;
// entry contents are not cleared.
module ordered_array_list_engine #(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// kind[2:0], position[7:3], value[39:8]
	input  logic [oal_pkg::S_TDATA_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// value_out[31:0], status[33:32], count[38:34], zero[39]
	output logic [oal_pkg::M_TDATA_W-1:0] m_tdata
);
	import oal_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

	typedef enum logic {
		IDLE,
		EXEC
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      count_q;
	logic [KIND_W-1:0]     kind_q;
	logic [POS_W-1:0]      pos_q;
	logic [DATA_WIDTH-1:0] word_q;

	logic                  out_valid_q;
	logic [VALUE_W-1:0]    vout_q;
	logic [STAT_W-1:0]     status_q;
	logic [COUNT_W-1:0]    cnt_out_q;

	logic [KIND_W-1:0]     in_kind;
	logic [POS_W-1:0]      in_pos;
	logic [DATA_WIDTH-1:0] in_word;
	logic                  in_xfer;
	logic                  commit;

	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]   cell_hit;
	logic [CAPACITY-1:0]   live;
	logic [CAPACITY-1:0]   hits;
	logic [CAPACITY-1:0]   first_hit;
	logic                  any_hit;
	logic [IDX_W-1:0]      hit_idx;

	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;

	op_t                   op;
	cell_ctl_t             ctl;
	logic [IDX_W-1:0]      tgt;
	logic [DATA_WIDTH-1:0] cell_word;
	logic [DATA_WIDTH-1:0] old_word;
	logic [DATA_WIDTH-1:0] vout;
	logic [STAT_W-1:0]     status;
	logic [CNT_W-1:0]      count_nx;

	assign in_kind = s_tdata[KIND_W-1:0];
	assign in_pos  = s_tdata[KIND_W +: POS_W];
	assign in_word = DATA_WIDTH'(64'(s_tdata[KIND_W+POS_W +: VALUE_W]));

	assign s_tready = (state_q == IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign commit   = (state_q == EXEC) && (!out_valid_q || m_tready);

	// entries at or beyond the count never match
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			live[i] = (CNT_W'(i) < count_q);
		end
	end
	assign hits      = cell_hit & live;
	assign any_hit   = |hits;
	assign first_hit = hits & (~hits + CAPACITY'(1));

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	assign pos_ext  = CMP_W'(pos_q);
	assign cnt_ext  = CMP_W'(count_q);
	assign old_word = cell_data[tgt];

	always_comb begin
		op       = OP_NONE;
		tgt      = '0;
		vout     = '0;
		status   = ST_MISS;
		count_nx = count_q;
		unique case (kind_q)
			K_INSERT_AT: begin
				if (count_q == FULL_CNT) begin
					status = ST_FULL;
				end else begin
					tgt      = (pos_ext > cnt_ext) ? IDX_W'(count_q) : IDX_W'(pos_q);
					op       = OP_INS;
					status   = ST_OK;
					count_nx = count_q + CNT_W'(1);
				end
			end
			K_REMOVE_VALUE: begin
				tgt = hit_idx;
				if (any_hit) begin
					op       = OP_DEL;
					vout     = old_word;
					status   = ST_OK;
					count_nx = count_q - CNT_W'(1);
				end
			end
			K_REMOVE_AT: begin
				tgt = IDX_W'(pos_q);
				if (pos_ext < cnt_ext) begin
					op       = OP_DEL;
					vout     = old_word;
					status   = ST_OK;
					count_nx = count_q - CNT_W'(1);
				end
			end
			K_POP_BACK: begin
				tgt = IDX_W'(count_q - CNT_W'(1));
				if (count_q == '0) begin
					status = ST_EMPTY;
				end else begin
					op       = OP_DEL;
					vout     = old_word;
					status   = ST_OK;
					count_nx = count_q - CNT_W'(1);
				end
			end
			K_REPLACE_AT: begin
				tgt = IDX_W'(pos_q);
				if (pos_ext < cnt_ext) begin
					op     = OP_REPL;
					vout   = old_word;
					status = ST_OK;
				end
			end
			K_MEMBER_TEST: begin
				if (any_hit) begin
					vout   = word_q;
					status = ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign ctl.op     = commit ? op : OP_NONE;
	assign ctl.cmp_en = in_xfer;
	// search word on the transfer, write word at commit
	assign cell_word  = in_xfer ? in_word : word_q;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d;
		logic [DATA_WIDTH-1:0] next_d;
		if (g == 0) begin : g_first
			assign prev_d = '0;
		end else begin : g_mid_p
			assign prev_d = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid_n
			assign next_d = cell_data[g+1];
		end
		oal_cell #(
			.IDX       (g),
			.IDX_W     (IDX_W),
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.tgt      (tgt),
			.word     (cell_word),
			.prev_data(prev_d),
			.next_data(next_d),
			.data     (cell_data[g]),
			.hit      (cell_hit[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_xfer) begin
						state_q <= EXEC;
					end
				end
				EXEC: begin
					if (commit) begin
						state_q <= IDLE;
						count_q <= count_nx;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q <= in_kind;
			pos_q  <= in_pos;
			word_q <= in_word;
		end
		if (commit) begin
			vout_q    <= VALUE_W'(64'(vout));
			status_q  <= status;
			cnt_out_q <= COUNT_W'(count_nx);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, cnt_out_q, status_q, vout_q};

endmodule
